// ===== rtl/pitl_pkg.sv =====
// shared constants and types for the palette index bitplane tiler
package pitl_pkg;

	localparam int PALETTE_SIZE = 4;
	localparam int ROW_BITS     = 8;
	localparam int TILE_COLS    = 8;
	localparam int TILE_ROWS    = 8;

	localparam int COLOR_W = 32;
	localparam int COORD_W = 3;
	localparam int IDX_W   = $clog2(PALETTE_SIZE);
	localparam int USED_W  = $clog2(PALETTE_SIZE + 1);
	localparam int PLANE_W = 64;
	localparam int POS_W   = $clog2(PLANE_W);

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [USED_W-1:0]  used_t;
	typedef logic [PLANE_W-1:0] plane_t;
	typedef logic [POS_W-1:0]   pos_t;

	// palette lookup outcome for one pixel
	typedef struct packed {
		idx_t color_index;
		logic color_added;
		logic overflow;
	} pal_res_t;

endpackage

// ===== rtl/pitl_pix_if.sv =====
// pixel input channel
interface pitl_pix_if;
	logic             valid;
	logic             ready;
	pitl_pkg::color_t pixel_color;
	pitl_pkg::coord_t tile_col;
	pitl_pkg::coord_t tile_row;
	logic             last_of_tile;
	logic             sheet_start;

	modport source (output valid, pixel_color, tile_col, tile_row, last_of_tile, sheet_start,
		input ready);
	modport sink (input valid, pixel_color, tile_col, tile_row, last_of_tile, sheet_start,
		output ready);
endinterface

// ===== rtl/pitl_res_if.sv =====
// result output channel
interface pitl_res_if;
	logic             valid;
	logic             ready;
	pitl_pkg::idx_t   color_index;
	logic             color_added;
	logic             overflow;
	logic             tile_done;
	pitl_pkg::plane_t plane_low;
	pitl_pkg::plane_t plane_high;

	modport source (output valid, color_index, color_added, overflow, tile_done, plane_low,
		plane_high, input ready);
	modport sink (input valid, color_index, color_added, overflow, tile_done, plane_low,
		plane_high, output ready);
endinterface

// ===== rtl/pitl_palette.sv =====
// four-entry palette: parallel match, fill in order of first appearance, sticky overflow
module pitl_palette (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  pitl_pkg::color_t   color,
	input  logic               sheet_start,
	output pitl_pkg::pal_res_t res
);

	pitl_pkg::color_t entries_q [pitl_pkg::PALETTE_SIZE];
	pitl_pkg::used_t  used_q;
	logic             ovf_q;

	pitl_pkg::used_t  used_eff;
	logic             ovf_eff;
	logic             found;
	pitl_pkg::idx_t   match_idx;
	logic             full;

	// sheet start clears before this pixel; lowest matching entry wins
	always_comb begin
		used_eff  = sheet_start ? '0 : used_q;
		ovf_eff   = sheet_start ? 1'b0 : ovf_q;
		found     = 1'b0;
		match_idx = '0;
		for (int i = pitl_pkg::PALETTE_SIZE - 1; i >= 0; i--) begin
			if (pitl_pkg::USED_W'(i) < used_eff && entries_q[i] == color) begin
				found     = 1'b1;
				match_idx = pitl_pkg::IDX_W'(i);
			end
		end
		full            = used_eff == pitl_pkg::USED_W'(pitl_pkg::PALETTE_SIZE);
		res.color_index = match_idx;
		res.color_added = 1'b0;
		res.overflow    = ovf_eff;
		if (!found) begin
			if (!full) begin
				res.color_index = used_eff[pitl_pkg::IDX_W-1:0];
				res.color_added = 1'b1;
			end else begin
				res.color_index = '0;
				res.overflow    = 1'b1;
			end
		end
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ovf_q  <= 1'b0;
		end else if (step) begin
			used_q <= res.color_added ? used_eff + pitl_pkg::USED_W'(1) : used_eff;
			ovf_q  <= res.overflow;
		end
	end

	// palette entries, only ever read below the fill count
	always_ff @(posedge clk) begin
		if (step && res.color_added) begin
			entries_q[used_eff[pitl_pkg::IDX_W-1:0]] <= color;
		end
	end

endmodule

// ===== rtl/pitl_planes.sv =====
// two bitplane accumulators, handed out and cleared on the last pixel of a tile
module pitl_planes (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pitl_pkg::idx_t   color_index,
	input  pitl_pkg::coord_t tile_col,
	input  pitl_pkg::coord_t tile_row,
	input  logic             last_of_tile,
	output pitl_pkg::plane_t plane_low,
	output pitl_pkg::plane_t plane_high
);

	pitl_pkg::plane_t low_acc_q;
	pitl_pkg::plane_t high_acc_q;
	pitl_pkg::plane_t low_next;
	pitl_pkg::plane_t high_next;
	pitl_pkg::pos_t   pos;
	logic             in_tile;

	// bit position: row 0 lands in the top byte
	always_comb begin
		in_tile = (int'(tile_col) < pitl_pkg::TILE_COLS) &&
			(int'(tile_row) < pitl_pkg::TILE_ROWS);
		pos = pitl_pkg::POS_W'(pitl_pkg::ROW_BITS * (pitl_pkg::TILE_ROWS - 1 - int'(tile_row)) +
			int'(tile_col));
		low_next  = low_acc_q | (pitl_pkg::PLANE_W'(in_tile & color_index[0]) << pos);
		high_next = high_acc_q |
			(pitl_pkg::PLANE_W'(in_tile & color_index[pitl_pkg::IDX_W-1]) << pos);
	end

	assign plane_low  = last_of_tile ? low_next : '0;
	assign plane_high = last_of_tile ? high_next : '0;

	// accumulate, clear after a finished tile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_acc_q  <= '0;
			high_acc_q <= '0;
		end else if (step) begin
			low_acc_q  <= last_of_tile ? '0 : low_next;
			high_acc_q <= last_of_tile ? '0 : high_next;
		end
	end

endmodule

// ===== rtl/palette_index_bitplane_tiler_unit.sv =====
// A pixel passes the input register, then the result register, before its result valid rises.
// Throughput: one pixel per cycle while results are taken; the palette compare and plane update fit in one stage.
// A stalled result lets one more pixel into the input register, then holds pixel ready low.
// Reset clears the palette fill count, overflow flag, plane accumulators and stage valids.
// Top level of the palette index bitplane tiler
module palette_index_bitplane_tiler_unit (
	input  logic       clk,
	input  logic       arst_n,
	pitl_pix_if.sink   pixel,
	pitl_res_if.source result
);

	logic               valid_s1;
	pitl_pkg::color_t   color_s1;
	pitl_pkg::coord_t   col_s1;
	pitl_pkg::coord_t   row_s1;
	logic               last_s1;
	logic               start_s1;

	logic               valid_s2;
	pitl_pkg::pal_res_t pal_s2;
	logic               done_s2;
	pitl_pkg::plane_t   low_s2;
	pitl_pkg::plane_t   high_s2;

	logic               adv_s2;
	logic               step;
	pitl_pkg::pal_res_t pal_res;
	pitl_pkg::plane_t   plane_low;
	pitl_pkg::plane_t   plane_high;

	// stage flow control
	assign adv_s2      = !valid_s2 || result.ready;
	assign step        = valid_s1 && adv_s2;
	assign pixel.ready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			color_s1 <= pixel.pixel_color;
			col_s1   <= pixel.tile_col;
			row_s1   <= pixel.tile_row;
			last_s1  <= pixel.last_of_tile;
			start_s1 <= pixel.sheet_start;
		end
	end

	pitl_palette u_palette (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.color       (color_s1),
		.sheet_start (start_s1),
		.res         (pal_res)
	);

	pitl_planes u_planes (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.color_index  (pal_res.color_index),
		.tile_col     (col_s1),
		.tile_row     (row_s1),
		.last_of_tile (last_s1),
		.plane_low    (plane_low),
		.plane_high   (plane_high)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pal_s2  <= pal_res;
			done_s2 <= last_s1;
			low_s2  <= plane_low;
			high_s2 <= plane_high;
		end
	end

	assign result.valid       = valid_s2;
	assign result.color_index = pal_s2.color_index;
	assign result.color_added = pal_s2.color_added;
	assign result.overflow    = pal_s2.overflow;
	assign result.tile_done   = done_s2;
	assign result.plane_low   = low_s2;
	assign result.plane_high  = high_s2;

`ifndef SYNTH
	// planes are only nonzero on a finished tile
	a_planes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.tile_done |-> result.plane_low == '0 && result.plane_high == '0)
		else $error("plane data on a result without tile_done");

	// a new entry can never be added once the palette has overflowed
	a_add_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.color_added |-> !result.overflow)
		else $error("color added while overflow set");

	// an accepted pixel is held in the input stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> valid_s1)
		else $error("accepted pixel lost from input stage");

	// a stalled result stays in the output register
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> valid_s2 && $stable(pal_s2))
		else $error("stalled result dropped or changed");
`endif

endmodule

// ===== tb/pitl_result_checker.sv =====
// result checker for the palette index bitplane tiler: predicts every result and compares
module pitl_result_checker (
	input  logic clk,
	input  logic arst_n,
	pitl_pix_if  pix,
	pitl_res_if  res,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen,
	output int   tiles_seen,
	output int   overflow_seen
);

	// one predicted result transaction
	typedef struct packed {
		pitl_pkg::pal_res_t lookup;
		logic               tile_done;
		pitl_pkg::plane_t   plane_low;
		pitl_pkg::plane_t   plane_high;
	} tile_out_t;

	// predictor state
	pitl_pkg::color_t palette [pitl_pkg::PALETTE_SIZE];
	pitl_pkg::used_t  fill_count;
	pitl_pkg::plane_t low_acc;
	pitl_pkg::plane_t high_acc;
	logic             ovf_sticky;

	tile_out_t predicted_results [$];
	tile_out_t want;

	// one line per mismatch
	task automatic report_mismatch(string what, pitl_pkg::plane_t got,
		pitl_pkg::plane_t exp_val);
		$display("%0t checker: %s mismatch, got %h expected %h (result %0d)",
			$time, what, got, exp_val, results_seen);
		mismatches++;
	endtask

	task automatic check_field(string what, pitl_pkg::plane_t got, pitl_pkg::plane_t exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	function automatic void clear_palette();
		int i;
		for (i = 0; i < pitl_pkg::PALETTE_SIZE; i++)
			palette[i] = '0;
		fill_count = '0;
		ovf_sticky = 1'b0;
	endfunction

	// palette match, plane update and tile output for one pixel
	function automatic tile_out_t encode_pixel(pitl_pkg::color_t color, pitl_pkg::coord_t col,
		pitl_pkg::coord_t row, logic last, logic start);
		tile_out_t      r;
		pitl_pkg::idx_t idx;
		logic           hit;
		int             pos;
		int             i;
		r   = '0;
		idx = '0;
		hit = 1'b0;
		if (start)
			clear_palette();
		for (i = 0; i < pitl_pkg::PALETTE_SIZE; i++) begin
			if (!hit && i < int'(fill_count) && palette[i] == color) begin
				idx = pitl_pkg::idx_t'(i);
				hit = 1'b1;
			end
		end
		// new color takes the next free entry, or trips the sticky overflow
		if (!hit) begin
			if (int'(fill_count) < pitl_pkg::PALETTE_SIZE) begin
				palette[fill_count[pitl_pkg::IDX_W-1:0]] = color;
				idx = pitl_pkg::idx_t'(fill_count);
				fill_count = fill_count + pitl_pkg::used_t'(1);
				r.lookup.color_added = 1'b1;
			end else begin
				ovf_sticky = 1'b1;
				idx = '0;
			end
		end
		if (int'(col) < pitl_pkg::TILE_COLS && int'(row) < pitl_pkg::TILE_ROWS) begin
			pos = pitl_pkg::ROW_BITS * (pitl_pkg::TILE_ROWS - 1 - int'(row)) + int'(col);
			low_acc[pos]  = low_acc[pos] | idx[0];
			high_acc[pos] = high_acc[pos] | idx[1];
		end
		r.lookup.color_index = idx;
		r.lookup.overflow    = ovf_sticky;
		r.tile_done          = last;
		if (last) begin
			r.plane_low  = low_acc;
			r.plane_high = high_acc;
			low_acc  = '0;
			high_acc = '0;
		end
		return r;
	endfunction

	// watch both channels: compare the result transaction, then predict the pixel transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_palette();
			low_acc  = '0;
			high_acc = '0;
			predicted_results.delete();
			mismatches    = 0;
			outstanding   = 0;
			results_seen  = 0;
			tiles_seen    = 0;
			overflow_seen = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result", '0, '0);
				end else begin
					want = predicted_results.pop_front();
					check_field("color_index", pitl_pkg::plane_t'(res.color_index),
						pitl_pkg::plane_t'(want.lookup.color_index));
					check_field("color_added", pitl_pkg::plane_t'(res.color_added),
						pitl_pkg::plane_t'(want.lookup.color_added));
					check_field("overflow", pitl_pkg::plane_t'(res.overflow),
						pitl_pkg::plane_t'(want.lookup.overflow));
					check_field("tile_done", pitl_pkg::plane_t'(res.tile_done),
						pitl_pkg::plane_t'(want.tile_done));
					check_field("plane_low", res.plane_low, want.plane_low);
					check_field("plane_high", res.plane_high, want.plane_high);
					if (want.tile_done)
						tiles_seen++;
					if (want.lookup.overflow)
						overflow_seen++;
				end
				results_seen++;
			end
			if (pix.valid && pix.ready)
				predicted_results.push_back(encode_pixel(pix.pixel_color, pix.tile_col,
					pix.tile_row, pix.last_of_tile, pix.sheet_start));
			outstanding = predicted_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the tiler testbench: clock, reset, pixel stimulus, result back-pressure and verdict
module tb_top;

	localparam int ITEM_TARGET = 1716;

	logic clk = 1'b0;
	logic arst_n;
	logic idle_on;
	int   sent;
	int   mismatches;
	int   outstanding;
	int   results_seen;
	int   tiles_seen;
	int   overflow_seen;

	pitl_pix_if pix_ch ();
	pitl_res_if res_ch ();

	palette_index_bitplane_tiler_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_ch),
		.result (res_ch)
	);

	pitl_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix           (pix_ch),
		.res           (res_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.tiles_seen    (tiles_seen),
		.overflow_seen (overflow_seen)
	);

	always #5 clk = ~clk;

	// random result back-pressure
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= !(idle_on && $urandom_range(99) < 12);
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("tb_top: timeout reached with %0d results outstanding", outstanding);
		$display("tb_top: FAIL");
		$finish;
	end

	// present one pixel transaction and hold it until accepted
	task automatic send_pixel(pitl_pkg::color_t color, pitl_pkg::coord_t col,
		pitl_pkg::coord_t row, logic last, logic start);
		if (idle_on && $urandom_range(99) < 6) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix_ch.valid        <= 1'b1;
		pix_ch.pixel_color  <= color;
		pix_ch.tile_col     <= col;
		pix_ch.tile_row     <= row;
		pix_ch.last_of_tile <= last;
		pix_ch.sheet_start  <= start;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// palette colors lean on all-zero and all-one extremes now and then
	function automatic pitl_pkg::color_t pick_color();
		int sel;
		sel = $urandom_range(15);
		if (sel == 0)
			return '0;
		else if (sel == 1)
			return '1;
		return $urandom;
	endfunction

	initial begin : stimulus
		pitl_pkg::color_t sheet_colors [5];
		int               n_colors;
		int               tiles_left;
		int               kind;
		int               len;
		int               break_at;
		int               guard;
		int               i;
		int               r;
		int               c;
		logic             start_flag;

		arst_n              = 1'b0;
		idle_on             <= 1'b1;
		pix_ch.valid        <= 1'b0;
		pix_ch.pixel_color  <= '0;
		pix_ch.tile_col     <= '0;
		pix_ch.tile_row     <= '0;
		pix_ch.last_of_tile <= 1'b0;
		pix_ch.sheet_start  <= 1'b0;
		sent       = 0;
		tiles_left = 0;
		n_colors   = 1;
		start_flag = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: palette fill, overflow, hits after overflow, sheet starts, tile output
		send_pixel(32'h0000_0000, 3'd0, 3'd0, 1'b0, 1'b1);
		send_pixel(32'hFFFF_FFFF, 3'd7, 3'd7, 1'b0, 1'b0);
		send_pixel(32'h0000_0000, 3'd1, 3'd0, 1'b0, 1'b0);
		send_pixel(32'hA5A5_A5A5, 3'd7, 3'd0, 1'b0, 1'b0);
		send_pixel(32'h5A5A_5A5A, 3'd0, 3'd7, 1'b0, 1'b0);
		send_pixel(32'h1234_5678, 3'd2, 3'd3, 1'b0, 1'b0);
		send_pixel(32'h5A5A_5A5A, 3'd3, 3'd3, 1'b0, 1'b0);
		send_pixel(32'hFFFF_FFFF, 3'd7, 3'd7, 1'b1, 1'b0);
		send_pixel(32'h0000_0000, 3'd4, 3'd4, 1'b1, 1'b0);
		send_pixel(32'h1234_5678, 3'd5, 3'd2, 1'b0, 1'b1);
		send_pixel(32'hDEAD_BEEF, 3'd6, 3'd1, 1'b0, 1'b0);
		send_pixel(32'hCAFE_F00D, 3'd0, 3'd0, 1'b0, 1'b0);
		send_pixel(32'h0000_FFFF, 3'd1, 3'd1, 1'b0, 1'b0);
		send_pixel(32'h8765_4321, 3'd0, 3'd6, 1'b0, 1'b1);
		send_pixel(32'h0000_FFFF, 3'd7, 3'd0, 1'b1, 1'b0);
		send_pixel(32'hFFFF_FFFF, 3'd3, 3'd5, 1'b1, 1'b1);

		// random: sheets of raster tiles over a small palette, short tiles and noise
		while (sent < ITEM_TARGET) begin
			idle_on <= !(sent >= 700 && sent < 1100);
			if (tiles_left == 0) begin
				n_colors = $urandom_range(1, 5);
				for (i = 0; i < 5; i++)
					sheet_colors[i] = pick_color();
				tiles_left = $urandom_range(1, 4);
				start_flag = 1'b1;
			end
			kind = $urandom_range(99);
			if (kind < 65) begin
				// full tile in raster order, sometimes with a sheet start partway through
				break_at = (kind < 8) ? $urandom_range(1, 62) : -1;
				for (i = 0; i < 64; i++) begin
					if (i == break_at) begin
						n_colors = $urandom_range(1, 5);
						for (c = 0; c < 5; c++)
							sheet_colors[c] = pick_color();
						start_flag = 1'b1;
					end
					r = i / 8;
					c = i % 8;
					send_pixel(sheet_colors[$urandom_range(0, n_colors - 1)],
						pitl_pkg::coord_t'(c), pitl_pkg::coord_t'(r), i == 63, start_flag);
					start_flag = 1'b0;
				end
				tiles_left--;
			end else if (kind < 85) begin
				// short tile with scattered and repeated positions
				len = $urandom_range(1, 12);
				for (i = 0; i < len; i++) begin
					send_pixel(sheet_colors[$urandom_range(0, n_colors - 1)],
						pitl_pkg::coord_t'($urandom_range(7)),
						pitl_pkg::coord_t'($urandom_range(7)),
						i == len - 1, start_flag);
					start_flag = 1'b0;
				end
				tiles_left--;
			end else begin
				// noise: every field random
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++)
					send_pixel($urandom, pitl_pkg::coord_t'($urandom_range(7)),
						pitl_pkg::coord_t'($urandom_range(7)), $urandom_range(7) == 0,
						$urandom_range(15) == 0);
			end
		end
		pix_ch.valid <= 1'b0;
		idle_on      <= 1'b1;

		// drain the results still in flight
		guard = 0;
		while (outstanding != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);

		$display("tb_top: %0d pixels sent, %0d results checked, %0d finished tiles",
			sent, results_seen, tiles_seen);
		$display("tb_top: %0d results carried the overflow flag, %0d mismatches, %0d missing",
			overflow_seen, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
